// ===== hdl/noise_signal_level_detector_assert.svh =====
// Assertion macros used by the checker file of the level detector.
// No dependencies.
`ifndef NOISE_SIGNAL_LEVEL_DETECTOR_ASSERT_SVH
`define NOISE_SIGNAL_LEVEL_DETECTOR_ASSERT_SVH
`define NSLD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NSLD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/nsld_pkg.sv =====
// Types and constants of the noise signal level detector.
// No dependencies.
`default_nettype none
package nsld_pkg;
  localparam int unsigned EW = 43;
  localparam logic [2:0] REG_BLEN = 3'd0;
  localparam logic [2:0] REG_WIN = 3'd1;
  localparam logic [2:0] REG_UPD = 3'd2;
  localparam logic [2:0] REG_SLOPE = 3'd3;
  localparam logic [2:0] REG_OFFS = 3'd4;
  localparam logic [2:0] REG_BOGUS = 3'd5;
  localparam logic [19:0] LOG10_2_Q20 = 20'd315653;
  localparam logic [20:0] COMP_Q16 = 21'd16384;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_RD, ST_SCAN, ST_LOGL, ST_LOGI, ST_OUT
  } state_e;

  typedef struct packed {
    logic accum;     // add sample, update counters
    logic rd_start;  // start scan at newest entry
    logic rd_step;   // compare current entry, advance
    logic log_start; // start log on selected energy
    logic log_sel_min;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic nonempty;
    logic scan_last;
    logic log_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== hdl/nsld_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module nsld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/nsld_ctrl.sv =====
// Controller state machine of the level detector.
// Depends on nsld_pkg.
`default_nettype none
module nsld_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire nsld_pkg::sts_t sts_i,
  output nsld_pkg::cmd_t      cmd_o
);
  nsld_pkg::state_e state_q, state_d;
  logic ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nsld_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    ovalid_d = ovalid_q && !out_ready_i;
    case (state_q)
      nsld_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accum = 1'b1;
          state_d = nsld_pkg::ST_ACC;
        end
      end
      nsld_pkg::ST_ACC: begin
        cmd_o.rd_start = 1'b1;
        state_d = sts_i.nonempty ? nsld_pkg::ST_RD : nsld_pkg::ST_OUT;
      end
      nsld_pkg::ST_RD: state_d = nsld_pkg::ST_SCAN;
      nsld_pkg::ST_SCAN: begin
        cmd_o.rd_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = nsld_pkg::ST_LOGL;
          cmd_o.log_start = 1'b1;
        end
      end
      nsld_pkg::ST_LOGL: begin
        if (sts_i.log_done) begin
          cmd_o.log_start = 1'b1;
          cmd_o.log_sel_min = 1'b1;
          state_d = nsld_pkg::ST_LOGI;
        end
      end
      nsld_pkg::ST_LOGI: begin
        if (sts_i.log_done) state_d = nsld_pkg::ST_OUT;
      end
      nsld_pkg::ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = nsld_pkg::ST_IDLE;
        end
      end
      default: state_d = nsld_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/nsld_log.sv =====
// Iterative level unit: offset - slope*(log10(E) + optional comp term), with bogus check and saturation.
// Depends on nsld_pkg.
`default_nettype none
module nsld_log (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     comp_i,
  input  wire logic [nsld_pkg::EW-1:0]  energy_i,
  input  wire logic signed [15:0]       slope_i,
  input  wire logic signed [15:0]       offset_i,
  input  wire logic signed [15:0]       bogus_i,
  output logic                          done_o,
  output logic signed [15:0]            level_o
);
  typedef enum logic [2:0] {
    L_IDLE, L_NORM, L_SQ, L_L10, L_MUL, L_PRD, L_FIN
  } lst_e;
  lst_e st_q;
  logic [nsld_pkg::EW-1:0] e_q;
  logic [5:0] p_q;
  logic [31:0] m_q;
  logic [15:0] frac_q;
  logic [4:0] it_q;
  logic comp_q, zero_q;
  logic signed [22:0] l2_q;
  logic signed [43:0] l10p_q;
  logic signed [21:0] l10_q;
  logic signed [38:0] prod_q;
  logic signed [15:0] lev_q;
  logic done_q;
  logic [63:0] sq;
  logic [33:0] msq;
  logic [5:0] p_c;
  logic signed [20:0] lev_c;

  assign sq = {32'd0, m_q} * {32'd0, m_q};
  assign msq = sq[63:30];

  always_comb begin
    p_c = '0;
    for (int i = 0; i < nsld_pkg::EW; i++) begin
      if (e_q[i]) p_c = 6'(i);
    end
  end

  assign lev_c = 21'(offset_i) - 21'(prod_q >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= L_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        L_IDLE: if (start_i) st_q <= L_NORM;
        L_NORM: st_q <= L_SQ;
        L_SQ: if (it_q == 5'd15) st_q <= L_L10;
        L_L10: st_q <= L_MUL;
        L_MUL: st_q <= L_PRD;
        L_PRD: st_q <= L_FIN;
        L_FIN: begin
          st_q <= L_IDLE;
          done_q <= 1'b1;
        end
        default: st_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      L_IDLE: begin
        e_q <= energy_i;
        comp_q <= comp_i;
        zero_q <= (energy_i == '0);
        it_q <= '0;
        frac_q <= '0;
      end
      L_NORM: begin
        p_q <= p_c;
        if (p_c <= 6'd30) m_q <= 32'(e_q << (6'd30 - p_c));
        else m_q <= 32'(e_q >> (p_c - 6'd30));
      end
      L_SQ: begin
        it_q <= it_q + 5'd1;
        if (msq[31]) begin
          frac_q <= {frac_q[14:0], 1'b1};
          m_q <= msq[32:1];
        end else begin
          frac_q <= {frac_q[14:0], 1'b0};
          m_q <= msq[31:0];
        end
        if (it_q == 5'd0) l2_q <= 23'(($signed({1'b0, p_q}) - 7'sd30)) <<< 16;
      end
      L_L10: l10p_q <= (l2_q + $signed({7'd0, frac_q})) * $signed({1'b0, nsld_pkg::LOG10_2_Q20})
                       + 44'sd524288;
      L_MUL: begin
        l10_q <= 22'(l10p_q >>> 20) + (comp_q ? $signed({1'b0, nsld_pkg::COMP_Q16}) : 22'sd0);
      end
      L_PRD: ;
      L_FIN: ;
      default: ;
    endcase
    if (st_q == L_FIN) begin
      if (zero_q) lev_q <= '0;
      else if (lev_c > 21'(bogus_i)) lev_q <= '0;
      else if (lev_c > 21'sd32767) lev_q <= 16'sd32767;
      else if (lev_c < -21'sd32768) lev_q <= -16'sd32768;
      else lev_q <= lev_c[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= slope_i * l10_q + 39'sd32768;
  end

  assign done_o = done_q;
  assign level_o = lev_q;
endmodule
`default_nettype wire

// ===== hdl/nsld_dp.sv =====
// Datapath: energy accumulation, energy ring, window scan, log unit, result registers.
// Depends on nsld_pkg, nsld_ram, nsld_log.
`default_nettype none
module nsld_dp #(
  parameter int unsigned WindowDepth = 64,
  parameter int unsigned BlockLenMax = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [23:0]         cfg_data_i,
  input  wire logic signed [15:0]  sample_i,
  input  wire logic                chunk_end_i,
  input  wire nsld_pkg::cmd_t      cmd_i,
  output nsld_pkg::sts_t           sts_o,
  output logic signed [15:0]       integrated_level_o,
  output logic signed [15:0]       last_level_o,
  output logic                     window_nonempty_o,
  output logic                     block_done_o,
  output logic                     update_strobe_o
);
  localparam int unsigned AW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned FW = $clog2(WindowDepth + 1);
  localparam logic [12:0] BLMAX = (BlockLenMax > 8191) ? 13'h1FFF : 13'(BlockLenMax);
  localparam logic [AW-1:0] LAST = AW'(WindowDepth - 1);

  logic [12:0] blen_q;
  logic [6:0] win_q;
  logic [23:0] upd_q;
  logic signed [15:0] slope_q, offs_q, bogus_q;
  logic [nsld_pkg::EW-1:0] sum_q, min_q, sel_e;
  logic [12:0] cnt_q;
  logic [AW-1:0] head_q, ridx_q;
  logic [AW-1:0] ridx_n;
  logic [FW-1:0] fill_q, left_q, effw;
  logic [24:0] ucnt_q;
  logic done_q, strobe_q;
  logic signed [15:0] llev_q;
  logic [nsld_pkg::EW-1:0] rdata;
  logic [nsld_pkg::EW-1:0] newest_q;
  logic [nsld_pkg::EW-1:0] sum_n;
  logic [12:0] blen;
  logic [24:0] ucnt_n;
  logic ldone;
  logic signed [15:0] level;
  logic first_q;
  logic [31:0] sqr;

  assign effw = (32'(win_q) > WindowDepth) ? FW'(WindowDepth) : FW'(win_q);
  assign blen = (blen_q == '0) ? 13'd1 : (blen_q > BLMAX ? BLMAX : blen_q);
  assign sqr = 32'($signed(sample_i) * $signed(sample_i));
  assign sum_n = sum_q + nsld_pkg::EW'(sqr);
  assign ucnt_n = (ucnt_q == '1) ? ucnt_q : ucnt_q + 25'd1;
  assign ridx_n = (ridx_q == '0) ? LAST : ridx_q - AW'(1);

  nsld_ram #(.Width(nsld_pkg::EW), .Depth(WindowDepth)) u_ram (
    .clk_i, .we_i(cmd_i.accum && (cnt_q + 13'd1 >= blen)), .waddr_i(head_q),
    .wdata_i(sum_n), .raddr_i(cmd_i.rd_step ? ridx_n : ridx_q), .rdata_o(rdata)
  );

  assign sel_e = cmd_i.log_sel_min ? min_q : (first_q ? rdata : newest_q);

  nsld_log u_log (
    .clk_i, .rst_ni, .start_i(cmd_i.log_start), .comp_i(cmd_i.log_sel_min),
    .energy_i(sel_e), .slope_i(slope_q), .offset_i(offs_q), .bogus_i(bogus_q),
    .done_o(ldone), .level_o(level)
  );

  assign sts_o.nonempty = (fill_q != '0);
  assign sts_o.scan_last = (left_q <= FW'(1));
  assign sts_o.log_done = ldone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= 13'd160;
      win_q <= 7'd1;
      upd_q <= '0;
      slope_q <= 16'sd2560;
      offs_q <= '0;
      bogus_q <= 16'sd32767;
      sum_q <= '0;
      cnt_q <= '0;
      head_q <= '0;
      fill_q <= '0;
      ucnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nsld_pkg::REG_BLEN: blen_q <= cfg_data_i[12:0];
        nsld_pkg::REG_WIN: begin
          win_q <= cfg_data_i[6:0];
          if (fill_q > ((32'(cfg_data_i[6:0]) > WindowDepth) ? FW'(WindowDepth)
              : FW'(cfg_data_i[6:0])))
            fill_q <= (32'(cfg_data_i[6:0]) > WindowDepth) ? FW'(WindowDepth)
              : FW'(cfg_data_i[6:0]);
        end
        nsld_pkg::REG_UPD: begin
          upd_q <= cfg_data_i;
          ucnt_q <= '0;
        end
        nsld_pkg::REG_SLOPE, nsld_pkg::REG_OFFS: begin
          if (cfg_idx_i == nsld_pkg::REG_SLOPE) slope_q <= cfg_data_i[15:0];
          else offs_q <= cfg_data_i[15:0];
          sum_q <= '0;
          cnt_q <= '0;
          head_q <= '0;
          fill_q <= '0;
          ucnt_q <= '0;
        end
        nsld_pkg::REG_BOGUS: bogus_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end else if (cmd_i.accum) begin
      if (cnt_q + 13'd1 >= blen) begin
        sum_q <= '0;
        cnt_q <= '0;
        head_q <= (head_q == LAST) ? '0 : head_q + AW'(1);
        fill_q <= (fill_q + FW'(1) > effw) ? effw : fill_q + FW'(1);
      end else begin
        sum_q <= sum_n;
        cnt_q <= cnt_q + 13'd1;
      end
      if (upd_q != '0) begin
        ucnt_q <= (chunk_end_i && ucnt_n >= 25'(upd_q)) ? '0 : ucnt_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      done_q <= (cnt_q + 13'd1 >= blen);
      strobe_q <= (upd_q != '0) && chunk_end_i && (ucnt_n >= 25'(upd_q));
    end
    if (cmd_i.rd_start) begin
      ridx_q <= (head_q == '0) ? LAST : head_q - AW'(1);
      left_q <= fill_q;
      first_q <= 1'b1;
    end else if (cmd_i.rd_step) begin
      ridx_q <= ridx_n;
      left_q <= left_q - FW'(1);
      first_q <= 1'b0;
      if (first_q) newest_q <= rdata;
      if (first_q || rdata < min_q) min_q <= rdata;
    end
    if (cmd_i.log_start && cmd_i.log_sel_min) llev_q <= level;
    if (cmd_i.out_load) begin
      window_nonempty_o <= (fill_q != '0);
      block_done_o <= done_q;
      update_strobe_o <= strobe_q;
      integrated_level_o <= (fill_q != '0) ? level : '0;
      last_level_o <= (fill_q != '0) ? llev_q : '0;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/noise_signal_level_detector.sv =====
// Top level of the noise signal level detector.
// Depends on nsld_pkg, nsld_ctrl, nsld_dp.
//
// Input channel: sample_i/chunk_end_i requests under in_valid_i/in_ready_o.
// Output channel: one result per request under out_valid_o/out_ready_i.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i; the user
// must write it only while idle, which the block itself does not enforce.
// One request at a time. The time from accept to out_valid_o is set by the
// window scan (one ring entry a cycle from the RAM read port) and the log
// unit (run twice, once per level); an empty window skips both. The next
// request can be accepted in the cycle after the result is loaded.
// The result register holds its value while the receiver stalls; the next
// request is taken once it is free of work, and its result waits in the
// final state until the previous one is taken.
// Reset restores register defaults and clears the sums, ring head, fill
// and update counter; ring contents are never read before being written.
`default_nettype none
module noise_signal_level_detector #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned BLOCK_LEN_MAX = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               chunk_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      integrated_level_o,
  output logic signed [15:0]      last_level_o,
  output logic                    window_nonempty_o,
  output logic                    block_done_o,
  output logic                    update_strobe_o
);
  nsld_pkg::cmd_t cmd;
  nsld_pkg::sts_t sts;

  nsld_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  nsld_dp #(.WindowDepth(WINDOW_DEPTH), .BlockLenMax(BLOCK_LEN_MAX)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .sample_i, .chunk_end_i,
    .cmd_i(cmd), .sts_o(sts), .integrated_level_o, .last_level_o,
    .window_nonempty_o, .block_done_o, .update_strobe_o
  );
endmodule
`default_nettype wire

// ===== hdl/nsld_chk.sv =====
// Port-level checker for the level detector, bound to the top level.
// Depends on noise_signal_level_detector_assert.svh.
`default_nettype none
`include "noise_signal_level_detector_assert.svh"
module nsld_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic window_nonempty_o,
  input wire logic signed [15:0] integrated_level_o,
  input wire logic signed [15:0] last_level_o
);
  `NSLD_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `NSLD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(integrated_level_o))
  `NSLD_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, out_valid_o && !window_nonempty_o,
    integrated_level_o == 16'sd0 && last_level_o == 16'sd0)
endmodule
bind noise_signal_level_detector nsld_chk u_chk (.*);
`default_nettype wire
